@@ rtl/core/atv_pkg.sv @@
package atv_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int UNIT_FRAC_BITS  = 24;
    // pixel offsets go back to device units through (size << SCALE_SHIFT)
    localparam int SCALE_SHIFT     = UNIT_FRAC_BITS + 7 - COORD_FRAC_BITS;

    localparam int FIELD_W   = 20;
    localparam int FIELD_MAX = 2 ** (FIELD_W - 1) - 1;
    localparam int FIELD_MIN = -(2 ** (FIELD_W - 1));

    localparam int VIEW_W = 15;
    localparam int LEN_W  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEWPORT_WIDTH  = 2'd0,
        REG_VIEWPORT_HEIGHT = 2'd1,
        REG_ARROW_LENGTH    = 2'd2
    } cfg_reg_t;

    localparam logic [VIEW_W-1:0] WIDTH_RESET  = 15'd1024;
    localparam logic [VIEW_W-1:0] HEIGHT_RESET = 15'd768;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 16'd3072;

    // 0.42 = 21 / 50
    localparam int PERP_NUM = 21;
    localparam int PERP_DEN = 50;

    // |dir * size| < 2^34
    localparam int MAG_W  = 34;
    localparam int HALF_W = MAG_W / 2;
    localparam int RAD_W  = 2 * MAG_W + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 2;

    localparam int DIV_NUM_W = 60;
    localparam int DIV_DEN_W = 36;
    localparam int DIV_Q_W   = 26;

    localparam int UNIT_W  = UNIT_FRAC_BITS + 1;
    localparam int LEN21_W = LEN_W + 5;

endpackage

@@ rtl/core/atv_if.sv @@
interface atv_arrow_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [atv_pkg::FIELD_W-1:0]     tip_x;
    logic signed [atv_pkg::FIELD_W-1:0]     tip_y;
    logic signed [atv_pkg::FIELD_W-1:0]     dir_x;
    logic signed [atv_pkg::FIELD_W-1:0]     dir_y;

    modport source (output valid, output tip_x, output tip_y, output dir_x, output dir_y,
                    input ready);
    modport sink (input valid, input tip_x, input tip_y, input dir_x, input dir_y,
                  output ready);
endinterface

interface atv_vert_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [atv_pkg::FIELD_W-1:0]     out_tip_x;
    logic signed [atv_pkg::FIELD_W-1:0]     out_tip_y;
    logic signed [atv_pkg::FIELD_W-1:0]     left_x;
    logic signed [atv_pkg::FIELD_W-1:0]     left_y;
    logic signed [atv_pkg::FIELD_W-1:0]     right_x;
    logic signed [atv_pkg::FIELD_W-1:0]     right_y;

    modport source (output valid, output out_tip_x, output out_tip_y, output left_x,
                    output left_y, output right_x, output right_y, input ready);
    modport sink (input valid, input out_tip_x, input out_tip_y, input left_x,
                  input left_y, input right_x, input right_y, output ready);
endinterface

@@ rtl/core/arrowhead_triangle_vertices.sv @@
// Arrowhead triangle generator.
// arrow (sink): one arrow per item, tip and direction in signed Q3.16 device
// coordinates. vertices (source): the tip and the left and right base corners
// of the arrowhead, saturated to the 20-bit field range. An arrow whose
// direction has zero length, or any arrow while a viewport size or the arrow
// length register is zero, yields no vertices item.
// Configuration: cfg_we/cfg_index/cfg_data write viewport width (0), height (1)
// and arrow length in pixels, Q8.8 (2); write only while the block is empty.
// Throughput: one item per cycle while the skid register is empty. An item
// passes the 35-stage square root and two rounds of 26-stage dividers (unit
// vector, then offsets scaled back to device units) before it reaches vertices.
// Reset clears the pipeline valid bits and output buffer and loads the
// register defaults (1024 x 768, length 12.0).
// When vertices is stalled the finished item waits in the output register and
// a second one in a skid register; the pipeline then freezes and arrow.ready
// drops until the skid register drains. Nothing is lost or repeated.
module arrowhead_triangle_vertices (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [atv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [atv_pkg::CFG_DATA_W-1:0]      cfg_data,
    atv_arrow_if.sink                           arrow,
    atv_vert_if.source                          vertices
);

    localparam int FIELD_W = atv_pkg::FIELD_W;
    localparam int VIEW_W  = atv_pkg::VIEW_W;
    localparam int LEN_W   = atv_pkg::LEN_W;
    localparam int MAG_W   = atv_pkg::MAG_W;
    localparam int HALF_W  = atv_pkg::HALF_W;
    localparam int RAD_W   = atv_pkg::RAD_W;
    localparam int ROOT_W  = atv_pkg::ROOT_W;
    localparam int NUM_W   = atv_pkg::DIV_NUM_W;
    localparam int DEN_W   = atv_pkg::DIV_DEN_W;
    localparam int Q_W     = atv_pkg::DIV_Q_W;
    localparam int UNIT_W  = atv_pkg::UNIT_W;
    localparam int LEN21_W = atv_pkg::LEN21_W;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int SUM_W   = Q_W + 4;

    // sideband pipeline taps
    localparam int ST_D       = 3;
    localparam int ST_SQ_OUT  = ST_D + ROOT_W;
    localparam int ST_E       = ST_SQ_OUT + 1;
    localparam int ST_D1_OUT  = ST_E + Q_W;
    localparam int ST_F       = ST_D1_OUT + 1;
    localparam int ST_G       = ST_F + 1;
    localparam int ST_D2_OUT  = ST_G + Q_W;
    localparam int PIPE_DEPTH = ST_D2_OUT + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(atv_pkg::FIELD_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(atv_pkg::FIELD_MIN);

    typedef struct packed {
        logic signed [FIELD_W-1:0] tip_x;
        logic signed [FIELD_W-1:0] tip_y;
        logic                      a_neg;
        logic                      b_neg;
        logic [MAG_W-1:0]          a_mag;
        logic [MAG_W-1:0]          b_mag;
        logic                      nz;
    } side_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] tip_x;
        logic signed [FIELD_W-1:0] tip_y;
        logic signed [FIELD_W-1:0] left_x;
        logic signed [FIELD_W-1:0] left_y;
        logic signed [FIELD_W-1:0] right_x;
        logic signed [FIELD_W-1:0] right_y;
    } vert_t;

    function automatic logic signed [FIELD_W-1:0] sat_field(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[FIELD_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [VIEW_W-1:0]  width_reg;
    logic [VIEW_W-1:0]  height_reg;
    logic [LEN_W-1:0]   length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= atv_pkg::WIDTH_RESET;
            height_reg <= atv_pkg::HEIGHT_RESET;
            length_reg <= atv_pkg::LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atv_pkg::REG_VIEWPORT_WIDTH:  width_reg  <= cfg_data[VIEW_W-1:0];
                atv_pkg::REG_VIEWPORT_HEIGHT: height_reg <= cfg_data[VIEW_W-1:0];
                atv_pkg::REG_ARROW_LENGTH:    length_reg <= cfg_data[LEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // derived constants, settled long before any item reaches them
    logic [LEN21_W-1:0] len21_reg;
    logic [DEN_W-1:0]   den_bx_reg;
    logic [DEN_W-1:0]   den_by_reg;
    logic [DEN_W-1:0]   den_px_reg;
    logic [DEN_W-1:0]   den_py_reg;
    logic               cfg_ok_reg;

    always_ff @(posedge clk)
    begin
        len21_reg  <= LEN21_W'(length_reg) * LEN21_W'(atv_pkg::PERP_NUM);
        den_bx_reg <= DEN_W'(width_reg) << atv_pkg::SCALE_SHIFT;
        den_by_reg <= DEN_W'(height_reg) << atv_pkg::SCALE_SHIFT;
        den_px_reg <= (DEN_W'(width_reg) * DEN_W'(atv_pkg::PERP_DEN)) << atv_pkg::SCALE_SHIFT;
        den_py_reg <= (DEN_W'(height_reg) * DEN_W'(atv_pkg::PERP_DEN)) << atv_pkg::SCALE_SHIFT;
        cfg_ok_reg <= (width_reg != '0) && (height_reg != '0) && (length_reg != '0);
    end

    // ---------------- handshake ----------------
    logic  skid_valid_reg;
    logic  out_valid_reg;
    vert_t skid_reg;
    vert_t out_reg;
    logic  adv;

    assign adv         = !skid_valid_reg;
    assign arrow.ready = adv;

    logic [PIPE_DEPTH-1:0] v_reg;
    side_t                 sb_reg [PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], arrow.valid};
        end
    end

    // ---------------- stage A: scale direction to pixels ----------------
    logic signed [PROD_W-1:0] a_prod;
    logic signed [PROD_W-1:0] b_prod;
    logic [PROD_W-1:0]        a_abs;
    logic [PROD_W-1:0]        b_abs;
    side_t                    sb_in;

    always_comb
    begin
        a_prod = arrow.dir_x * $signed({1'b0, width_reg});
        b_prod = arrow.dir_y * $signed({1'b0, height_reg});
        a_abs  = a_prod[PROD_W-1] ? PROD_W'(-a_prod) : PROD_W'(a_prod);
        b_abs  = b_prod[PROD_W-1] ? PROD_W'(-b_prod) : PROD_W'(b_prod);
        sb_in.tip_x = arrow.tip_x;
        sb_in.tip_y = arrow.tip_y;
        sb_in.a_neg = a_prod[PROD_W-1];
        sb_in.b_neg = b_prod[PROD_W-1];
        sb_in.a_mag = a_abs[MAG_W-1:0];
        sb_in.b_mag = b_abs[MAG_W-1:0];
        sb_in.nz    = 1'b0;
    end

    // ---------------- stages B..D: sum of squares ----------------
    logic [MAG_W-1:0] a_hh_reg, a_hl_reg, a_ll_reg;
    logic [MAG_W-1:0] b_hh_reg, b_hl_reg, b_ll_reg;
    logic [RAD_W-1:0] sq_a_reg, sq_b_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [ROOT_W-1:0] root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_hh_reg <= MAG_W'(sb_reg[0].a_mag[MAG_W-1:HALF_W]) * MAG_W'(sb_reg[0].a_mag[MAG_W-1:HALF_W]);
            a_hl_reg <= MAG_W'(sb_reg[0].a_mag[MAG_W-1:HALF_W]) * MAG_W'(sb_reg[0].a_mag[HALF_W-1:0]);
            a_ll_reg <= MAG_W'(sb_reg[0].a_mag[HALF_W-1:0]) * MAG_W'(sb_reg[0].a_mag[HALF_W-1:0]);
            b_hh_reg <= MAG_W'(sb_reg[0].b_mag[MAG_W-1:HALF_W]) * MAG_W'(sb_reg[0].b_mag[MAG_W-1:HALF_W]);
            b_hl_reg <= MAG_W'(sb_reg[0].b_mag[MAG_W-1:HALF_W]) * MAG_W'(sb_reg[0].b_mag[HALF_W-1:0]);
            b_ll_reg <= MAG_W'(sb_reg[0].b_mag[HALF_W-1:0]) * MAG_W'(sb_reg[0].b_mag[HALF_W-1:0]);
            sq_a_reg <= (RAD_W'(a_hh_reg) << (2 * HALF_W)) + (RAD_W'(a_hl_reg) << (HALF_W + 1))
                        + RAD_W'(a_ll_reg);
            sq_b_reg <= (RAD_W'(b_hh_reg) << (2 * HALF_W)) + (RAD_W'(b_hl_reg) << (HALF_W + 1))
                        + RAD_W'(b_ll_reg);
            rad_reg  <= sq_a_reg + sq_b_reg;
        end
    end

    atv_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    // ---------------- stage E: unit vector numerators ----------------
    logic [NUM_W-1:0] num_ux_reg, num_uy_reg;
    logic [DEN_W-1:0] den_len_reg;
    logic [Q_W-1:0]   ux_mag, uy_mag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_ux_reg  <= (NUM_W'(sb_reg[ST_SQ_OUT].a_mag) << atv_pkg::UNIT_FRAC_BITS)
                           + NUM_W'(root >> 1);
            num_uy_reg  <= (NUM_W'(sb_reg[ST_SQ_OUT].b_mag) << atv_pkg::UNIT_FRAC_BITS)
                           + NUM_W'(root >> 1);
            den_len_reg <= DEN_W'(root);
        end
    end

    atv_div_pipe u_div_ux (.clk(clk), .en(adv), .num(num_ux_reg), .den(den_len_reg), .quo(ux_mag));
    atv_div_pipe u_div_uy (.clk(clk), .en(adv), .num(num_uy_reg), .den(den_len_reg), .quo(uy_mag));

    // ---------------- stages F, G: offsets in pixels, rounding bias ----------------
    logic [NUM_W-1:0] m_bx_reg, m_by_reg, m_px_reg, m_py_reg;
    logic [NUM_W-1:0] n_bx_reg, n_by_reg, n_px_reg, n_py_reg;
    logic [Q_W-1:0]   bx_mag, by_mag, px_mag, py_mag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_bx_reg <= NUM_W'(ux_mag[UNIT_W-1:0]) * NUM_W'(length_reg);
            m_by_reg <= NUM_W'(uy_mag[UNIT_W-1:0]) * NUM_W'(length_reg);
            m_px_reg <= NUM_W'(uy_mag[UNIT_W-1:0]) * NUM_W'(len21_reg);
            m_py_reg <= NUM_W'(ux_mag[UNIT_W-1:0]) * NUM_W'(len21_reg);
            n_bx_reg <= m_bx_reg + NUM_W'(den_bx_reg >> 1);
            n_by_reg <= m_by_reg + NUM_W'(den_by_reg >> 1);
            n_px_reg <= m_px_reg + NUM_W'(den_px_reg >> 1);
            n_py_reg <= m_py_reg + NUM_W'(den_py_reg >> 1);
        end
    end

    atv_div_pipe u_div_bx (.clk(clk), .en(adv), .num(n_bx_reg), .den(den_bx_reg), .quo(bx_mag));
    atv_div_pipe u_div_by (.clk(clk), .en(adv), .num(n_by_reg), .den(den_by_reg), .quo(by_mag));
    atv_div_pipe u_div_px (.clk(clk), .en(adv), .num(n_px_reg), .den(den_px_reg), .quo(px_mag));
    atv_div_pipe u_div_py (.clk(clk), .en(adv), .num(n_py_reg), .den(den_py_reg), .quo(py_mag));

    // sideband line, nz filled in once the length is known
    side_t sb_e;

    always_comb
    begin
        sb_e    = sb_reg[ST_E-1];
        sb_e.nz = (root != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= sb_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                sb_reg[i] <= (i == ST_E) ? sb_e : sb_reg[i-1];
            end
        end
    end

    // ---------------- final stage: vertices and saturation ----------------
    side_t                   sb_last;
    logic signed [SUM_W-1:0] tx, ty, bx, by, px, py;
    logic signed [SUM_W-1:0] lx, ly, rx, ry;
    vert_t                   inc;
    logic                    inc_valid;

    always_comb
    begin
        sb_last = sb_reg[ST_D2_OUT];
        tx = SUM_W'(sb_last.tip_x);
        ty = SUM_W'(sb_last.tip_y);
        bx = $signed(SUM_W'(bx_mag));
        by = $signed(SUM_W'(by_mag));
        px = $signed(SUM_W'(px_mag));
        py = $signed(SUM_W'(py_mag));
        if (sb_last.a_neg)
        begin
            bx = -bx;
            py = -py;
        end
        if (sb_last.b_neg)
        begin
            by = -by;
        end
        else
        begin
            // perpendicular x is minus uy
            px = -px;
        end
        lx = tx - bx + px;
        ly = ty - by + py;
        rx = tx - bx - px;
        ry = ty - by - py;
        inc.tip_x   = sb_last.tip_x;
        inc.tip_y   = sb_last.tip_y;
        inc.left_x  = sat_field(lx);
        inc.left_y  = sat_field(ly);
        inc.right_x = sat_field(rx);
        inc.right_y = sat_field(ry);
        inc_valid   = adv && v_reg[ST_D2_OUT] && sb_last.nz && cfg_ok_reg;
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || vertices.ready)
        begin
            out_valid_reg  <= skid_valid_reg || inc_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (inc_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || vertices.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : inc;
        end
        else if (inc_valid)
        begin
            skid_reg <= inc;
        end
    end

    assign vertices.valid     = out_valid_reg;
    assign vertices.out_tip_x = out_reg.tip_x;
    assign vertices.out_tip_y = out_reg.tip_y;
    assign vertices.left_x    = out_reg.left_x;
    assign vertices.left_y    = out_reg.left_y;
    assign vertices.right_x   = out_reg.right_x;
    assign vertices.right_y   = out_reg.right_y;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !vertices.ready))
        else $error("skid filled without an output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (arrow.valid && arrow.ready) |=> v_reg[0])
        else $error("accepted item missing from first stage");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vertices.ready) |=> out_valid_reg)
        else $error("stalled result dropped");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(v_reg))
        else $error("pipeline moved while the skid was full");

endmodule

@@ rtl/core/atv_sqrt_pipe.sv @@
module atv_sqrt_pipe (
    input  logic                          clk,
    input  logic                          en,
    input  logic [atv_pkg::RAD_W-1:0]     rad,
    output logic [atv_pkg::ROOT_W-1:0]    root
);

    localparam int RAD_W  = atv_pkg::RAD_W;
    localparam int ROOT_W = atv_pkg::ROOT_W;
    localparam int REM_W  = atv_pkg::SQRT_REM_W;
    localparam int T_W    = REM_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  x_reg    [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0]  rin;
        logic [RAD_W-1:0]  xin;
        logic [ROOT_W-1:0] qin;
        logic [T_W-1:0]    t;
        logic [T_W-1:0]    trial;
        logic [REM_W-1:0]  rout;
        logic [ROOT_W-1:0] qout;

        if (k == 0)
        begin : g_first
            assign rin = '0;
            assign xin = rad;
            assign qin = '0;
        end
        else
        begin : g_next
            assign rin = rem_reg[k-1];
            assign xin = x_reg[k-1];
            assign qin = root_reg[k-1];
        end

        always_comb
        begin
            t     = {rin, xin[RAD_W-1:RAD_W-2]};
            trial = T_W'({qin, 2'b01});
            if (t >= trial)
            begin
                rout = REM_W'(t - trial);
                qout = {qin[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rout = t[REM_W-1:0];
                qout = {qin[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= qout;
            end
        end

        if (k < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rout;
                    x_reg[k]   <= {xin[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

@@ rtl/core/atv_div_pipe.sv @@
module atv_div_pipe (
    input  logic                             clk,
    input  logic                             en,
    input  logic [atv_pkg::DIV_NUM_W-1:0]    num,
    input  logic [atv_pkg::DIV_DEN_W-1:0]    den,
    output logic [atv_pkg::DIV_Q_W-1:0]      quo
);

    localparam int NUM_W = atv_pkg::DIV_NUM_W;
    localparam int DEN_W = atv_pkg::DIV_DEN_W;
    localparam int Q_W   = atv_pkg::DIV_Q_W;

    logic [DEN_W-1:0] rem_reg [Q_W-1];
    logic [Q_W-1:0]   low_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   q_reg   [Q_W];

    // restoring division, one quotient bit per stage; the caller keeps
    // num < den << Q_W so the upper numerator bits start below den
    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rin;
        logic [DEN_W-1:0] dn;
        logic [Q_W-1:0]   lin;
        logic [Q_W-1:0]   qin;
        logic [DEN_W:0]   t;
        logic [DEN_W+1:0] diff;
        logic [DEN_W-1:0] rout;
        logic [Q_W-1:0]   qout;

        if (k == 0)
        begin : g_first
            assign rin = DEN_W'(num[NUM_W-1:Q_W]);
            assign lin = num[Q_W-1:0];
            assign dn  = den;
            assign qin = '0;
        end
        else
        begin : g_next
            assign rin = rem_reg[k-1];
            assign lin = low_reg[k-1];
            assign dn  = den_reg[k-1];
            assign qin = q_reg[k-1];
        end

        always_comb
        begin
            t    = {rin, lin[Q_W-1]};
            diff = {1'b0, t} - {2'b00, dn};
            if (!diff[DEN_W+1])
            begin
                rout = diff[DEN_W-1:0];
                qout = {qin[Q_W-2:0], 1'b1};
            end
            else
            begin
                rout = t[DEN_W-1:0];
                qout = {qin[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= qout;
            end
        end

        if (k < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rout;
                    low_reg[k] <= {lin[Q_W-2:0], 1'b0};
                    den_reg[k] <= dn;
                end
            end
        end
    end

    assign quo = q_reg[Q_W-1];

endmodule

@@ tb/atv_checker.sv @@
module atv_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [atv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atv_pkg::CFG_DATA_W-1:0] cfg_data,
    atv_arrow_if                           arrow,
    atv_vert_if                            vertices,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W = atv_pkg::FIELD_W;
    localparam int VIEW_W  = atv_pkg::VIEW_W;
    localparam int LEN_W   = atv_pkg::LEN_W;

    typedef logic signed [FIELD_W-1:0] coord_t;

    typedef struct packed {
        coord_t tip_x;
        coord_t tip_y;
        coord_t left_x;
        coord_t left_y;
        coord_t right_x;
        coord_t right_y;
    } triangle_t;

    logic [VIEW_W-1:0] width_q;
    logic [VIEW_W-1:0] height_q;
    logic [LEN_W-1:0]  length_q;
    triangle_t         expected_triangles[$];
    int                mismatches = 0;

    assign errors  = mismatches;
    assign pending = expected_triangles.size();

    function automatic longint root_of_sum(input logic [35:0] ma, input logic [35:0] mb);
        logic [71:0] rad;
        logic [71:0] sq;
        logic [35:0] r;
        logic [35:0] t;
        rad = {36'b0, ma} * {36'b0, ma} + {36'b0, mb} * {36'b0, mb};
        r = '0;
        for (int b = 35; b >= 0; b--)
        begin
            t = r | (36'd1 << b);
            sq = {36'b0, t} * {36'b0, t};
            if (sq <= rad)
                r = t;
        end
        return longint'({28'b0, r});
    endfunction

    // round to nearest, ties away from zero; den > 0
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > atv_pkg::FIELD_MAX)
            v = atv_pkg::FIELD_MAX;
        if (v < atv_pkg::FIELD_MIN)
            v = atv_pkg::FIELD_MIN;
        return coord_t'(v);
    endfunction

    function automatic bit arrowhead(input coord_t tx, input coord_t ty, input coord_t dx,
                                     input coord_t dy, output triangle_t tri_v);
        longint w, h, len, a, b, s, ux, uy, bx, by, px, py, scale;
        w = longint'(width_q);
        h = longint'(height_q);
        len = longint'(length_q);
        scale = 64'sd1 <<< atv_pkg::SCALE_SHIFT;
        tri_v = '0;
        if (w == 0 || h == 0 || len == 0)
            return 0;
        a = longint'(dx) * w;
        b = longint'(dy) * h;
        s = root_of_sum(36'((a < 0) ? -a : a), 36'((b < 0) ? -b : b));
        if (s == 0)
            return 0;
        ux = div_nearest(a * (64'sd1 <<< atv_pkg::UNIT_FRAC_BITS), s);
        uy = div_nearest(b * (64'sd1 <<< atv_pkg::UNIT_FRAC_BITS), s);
        bx = div_nearest(ux * len, w * scale);
        by = div_nearest(uy * len, h * scale);
        px = -div_nearest(uy * atv_pkg::PERP_NUM * len, atv_pkg::PERP_DEN * w * scale);
        py = div_nearest(ux * atv_pkg::PERP_NUM * len, atv_pkg::PERP_DEN * h * scale);
        tri_v.tip_x   = tx;
        tri_v.tip_y   = ty;
        tri_v.left_x  = clamp_coord(longint'(tx) - bx + px);
        tri_v.left_y  = clamp_coord(longint'(ty) - by + py);
        tri_v.right_x = clamp_coord(longint'(tx) - bx - px);
        tri_v.right_y = clamp_coord(longint'(ty) - by - py);
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input coord_t got, input coord_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        triangle_t tri_v;
        triangle_t want;
        if (!rst_n)
        begin
            width_q  <= atv_pkg::WIDTH_RESET;
            height_q <= atv_pkg::HEIGHT_RESET;
            length_q <= atv_pkg::LENGTH_RESET;
            expected_triangles.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    atv_pkg::REG_VIEWPORT_WIDTH:  width_q  <= cfg_data[VIEW_W-1:0];
                    atv_pkg::REG_VIEWPORT_HEIGHT: height_q <= cfg_data[VIEW_W-1:0];
                    atv_pkg::REG_ARROW_LENGTH:    length_q <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (arrow.valid && arrow.ready)
            begin
                if (arrowhead(arrow.tip_x, arrow.tip_y, arrow.dir_x, arrow.dir_y, tri_v))
                    expected_triangles.insert(expected_triangles.size(), tri_v);
            end
            if (vertices.valid && vertices.ready)
            begin
                if (expected_triangles.size() == 0)
                begin
                    report_mismatch("unexpected vertices item");
                end
                else
                begin
                    want = expected_triangles.pop_front();
                    check_field("out_tip_x", vertices.out_tip_x, want.tip_x);
                    check_field("out_tip_y", vertices.out_tip_y, want.tip_y);
                    check_field("left_x", vertices.left_x, want.left_x);
                    check_field("left_y", vertices.left_y, want.left_y);
                    check_field("right_x", vertices.right_x, want.right_x);
                    check_field("right_y", vertices.right_y, want.right_y);
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W    = atv_pkg::FIELD_W;
    localparam int CFG_IDX_W  = atv_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = atv_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY    = 94;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 190;

    typedef logic signed [FIELD_W-1:0] coord_t;

    localparam coord_t C_MAX  = coord_t'(atv_pkg::FIELD_MAX);
    localparam coord_t C_MIN  = coord_t'(atv_pkg::FIELD_MIN);
    localparam coord_t C_ZERO = coord_t'(0);
    localparam coord_t C_ONE  = coord_t'(1);
    localparam coord_t C_NEG1 = coord_t'(-1);

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycle;
    int                    quiet_cycles = 0;
    bit                    in_quiet;

    atv_arrow_if arrow ();
    atv_vert_if  vertices ();

    arrowhead_triangle_vertices u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .arrow     (arrow),
        .vertices  (vertices)
    );

    atv_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .arrow     (arrow),
        .vertices  (vertices),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // output stalls, with a quiet window
    initial
    begin
        vertices.ready = 0;
        cycle = 0;
        forever
        begin
            @(negedge clk);
            cycle++;
            vertices.ready = (cycle > 1000 && cycle < 3000) ? 1'b1 : ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if ((arrow.valid && arrow.ready) || (vertices.valid && vertices.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_arrow(input coord_t tx, input coord_t ty, input coord_t dx,
                              input coord_t dy);
        if (!in_quiet && $urandom_range(0, 99) < 25)
        begin
            arrow.valid = 0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        arrow.valid = 1;
        arrow.tip_x = tx;
        arrow.tip_y = ty;
        arrow.dir_x = dx;
        arrow.dir_y = dy;
        do @(posedge clk); while (!arrow.ready);
        @(negedge clk);
    endtask

    // let the pipeline empty, including arrows that make no item
    task automatic settle();
        arrow.valid = 0;
        wait (pending == 0);
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_view(input int w, input int h, input int len);
        write_reg(atv_pkg::REG_VIEWPORT_WIDTH, w);
        write_reg(atv_pkg::REG_VIEWPORT_HEIGHT, h);
        write_reg(atv_pkg::REG_ARROW_LENGTH, len);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, (1 << FIELD_W) - 1));
    endfunction

    function automatic coord_t any_dir();
        case ($urandom_range(0, 3))
            0: return coord_t'($signed($urandom_range(0, 64)) - 32);
            1: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
            default: return any_coord();
        endcase
    endfunction

    task automatic random_arrows(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_arrow(any_coord(), any_coord(), C_ZERO, C_ZERO);
            else
                send_arrow(any_coord(), any_coord(), any_dir(), any_dir());
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = atv_pkg::REG_VIEWPORT_WIDTH;
        cfg_data = '0;
        arrow.valid = 0;
        arrow.tip_x = '0;
        arrow.tip_y = '0;
        arrow.dir_x = '0;
        arrow.dir_y = '0;
        in_quiet = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed, reset settings
        send_arrow(C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        send_arrow(C_MAX, C_MIN, C_MAX, C_ZERO);
        send_arrow(C_MIN, C_MAX, C_MIN, C_MIN);
        send_arrow(C_MAX, C_MAX, C_MAX, C_MAX);
        send_arrow(C_MIN, C_MIN, C_ZERO, C_MIN);
        send_arrow(C_ZERO, C_ZERO, C_ONE, C_ZERO);
        send_arrow(C_ZERO, C_ZERO, C_ZERO, C_NEG1);
        send_arrow(coord_t'(100), coord_t'(-100), C_ONE, C_ONE);
        send_arrow(C_NEG1, C_NEG1, C_NEG1, C_MAX);
        send_arrow(C_MAX, C_ZERO, C_MIN, C_ONE);
        random_arrows(PHASE_ITEMS);
        settle();

        set_view(1, 1, 1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_arrow(C_MAX, C_MIN, C_ONE, C_ZERO);
        send_arrow(C_ZERO, C_ZERO, C_MIN, C_MAX);
        random_arrows(PHASE_ITEMS);
        settle();

        set_view(16384, 16384, 65535);
        send_arrow(C_MAX, C_MAX, C_MAX, C_MAX);
        send_arrow(C_MIN, C_MIN, C_MIN, C_MIN);
        send_arrow(C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        random_arrows(PHASE_ITEMS);
        settle();

        // zero registers block all results
        set_view(0, 768, 3072);
        random_arrows(20);
        settle();
        set_view(1024, 0, 3072);
        random_arrows(20);
        settle();
        set_view(1024, 768, 0);
        random_arrows(20);
        settle();

        set_view(16384, 1, 256);
        random_arrows(PHASE_ITEMS);
        settle();

        set_view(1, 16384, 65535);
        random_arrows(PHASE_ITEMS);
        settle();

        in_quiet = 1;
        set_view(640, 480, 3072);
        random_arrows(PHASE_ITEMS);
        in_quiet = 0;
        settle();

        for (int p = 0; p < 3; p++)
        begin
            set_view($urandom_range(1, 16384), $urandom_range(1, 16384),
                     $urandom_range(1, 65535));
            random_arrows(PHASE_ITEMS);
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/atv_pkg.sv
rtl/core/atv_if.sv
rtl/core/atv_sqrt_pipe.sv
rtl/core/atv_div_pipe.sv
rtl/core/arrowhead_triangle_vertices.sv
tb/atv_checker.sv
tb/tb.sv
